// ===== sv/ldf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldf_pkg
// shared types and constants of the diffuse lighting pipeline
// ----------------------------------------------------------------------------
package ldf_pkg;

    localparam logic [2:0] CFG_LIGHT_X      = 3'd0;
    localparam logic [2:0] CFG_LIGHT_Y      = 3'd1;
    localparam logic [2:0] CFG_LIGHT_Z      = 3'd2;
    localparam logic [2:0] CFG_DIFFUSE_RGBA = 3'd3;
    localparam logic [2:0] CFG_TEX_ENABLE   = 3'd4;

    localparam logic [16:0] FACTOR_ONE  = 17'd65536;
    localparam logic [17:0] AMBIENT_Q   = 18'd13107;
    localparam logic [26:0] ROUND_HALF  = 27'd32768;

    // data that rides along with the vector math
    typedef struct packed {
        logic [31:0]        rgba;
        logic signed [32:0] dot;
        logic               nz;
    } ldf_side_t;

    // what the divider hands to the shading stage
    typedef struct packed {
        logic [16:0] q;
        logic        pos;
        logic        ovf;
        logic [31:0] rgba;
    } ldf_fac_t;

endpackage

// ===== sv/ldf_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldf_if
// fragment and pixel channels of the diffuse lighting block
// ----------------------------------------------------------------------------
interface ldf_frag_if;
    logic        valid;
    logic        ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] norm_x;
    logic [31:0] norm_y;
    logic [31:0] norm_z;
    logic [7:0]  texel_r;
    logic [7:0]  texel_g;
    logic [7:0]  texel_b;
    logic [7:0]  texel_a;

    modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                    texel_r, texel_g, texel_b, texel_a, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  texel_r, texel_g, texel_b, texel_a, output ready);
endinterface

interface ldf_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_r;
    logic [7:0] out_g;
    logic [7:0] out_b;
    logic [7:0] out_a;

    modport source (output valid, out_r, out_g, out_b, out_a, input ready);
    modport sink (input valid, out_r, out_g, out_b, out_a, output ready);
endinterface
`default_nettype wire

// ===== sv/diffuse_lighting_fragment.sv =====
`timescale 1ns / 1ps
`default_nettype none
// throughput: one item per cycle while the pipeline is not stalled
// the pipeline is 57 stages plus a 2-entry output buffer
// the square root (32 stages) and the divider (18 stages) set the depth
// a stall holds the whole pipeline only when the output buffer is full
// reset clears all valid bits and the buffer, lights to 0, color to all ones
// ----------------------------------------------------------------------------
// diffuse_lighting_fragment
// per-fragment lambert diffuse shading with ambient term
// ----------------------------------------------------------------------------
module diffuse_lighting_fragment
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        cfg_we,
    input  wire  [2:0] cfg_index,
    input  wire [31:0] cfg_wdata,
    ldf_frag_if.sink   frag,
    ldf_pix_if.source  pix
);

    logic [31:0] light_x_reg;
    logic [31:0] light_y_reg;
    logic [31:0] light_z_reg;
    logic [31:0] diffuse_reg;
    logic        tex_en_reg;

    logic        en;
    logic [31:0] rgba_sel;

    logic               prep_v;
    logic [63:0]        prep_prod;
    ldf_pkg::ldf_side_t prep_side;
    logic               sq_v;
    logic [31:0]        sq_root;
    ldf_pkg::ldf_side_t sq_side;
    logic               dv_v;
    ldf_pkg::ldf_fac_t  dv_fac;

    logic [16:0] f;
    logic [17:0] lf;

    logic        sh1_v_reg;
    logic [17:0] sh1_lf_reg;
    logic [31:0] sh1_rgba_reg;
    logic        sh2_v_reg;
    logic [25:0] sh2_prod_reg [3];
    logic [7:0]  sh2_a_reg;

    logic [26:0] rounded [3];
    logic [7:0]  chan    [3];

    logic [31:0] buf_mem [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    logic        pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_x_reg <= 32'd0;
            light_y_reg <= 32'd0;
            light_z_reg <= 32'd0;
            diffuse_reg <= 32'hFFFF_FFFF;
            tex_en_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ldf_pkg::CFG_LIGHT_X:      light_x_reg <= cfg_wdata;
                ldf_pkg::CFG_LIGHT_Y:      light_y_reg <= cfg_wdata;
                ldf_pkg::CFG_LIGHT_Z:      light_z_reg <= cfg_wdata;
                ldf_pkg::CFG_DIFFUSE_RGBA: diffuse_reg <= cfg_wdata;
                ldf_pkg::CFG_TEX_ENABLE:   tex_en_reg  <= cfg_wdata[0];
                default:                   ;
            endcase
        end
    end

    // advance unless the last stage holds an item and the buffer is full
    assign en         = !(sh2_v_reg && (count_reg == 2'd2));
    assign frag.ready = en;

    assign rgba_sel = tex_en_reg ? {frag.texel_r, frag.texel_g, frag.texel_b, frag.texel_a}
                                 : diffuse_reg;

    ldf_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (frag.valid),
        .light_x   (light_x_reg),
        .light_y   (light_y_reg),
        .light_z   (light_z_reg),
        .pos_x     (frag.pos_x),
        .pos_y     (frag.pos_y),
        .pos_z     (frag.pos_z),
        .norm_x    (frag.norm_x),
        .norm_y    (frag.norm_y),
        .norm_z    (frag.norm_z),
        .rgba      (rgba_sel),
        .out_valid (prep_v),
        .out_prod  (prep_prod),
        .out_side  (prep_side)
    );

    ldf_isqrt u_isqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prep_v),
        .in_x      (prep_prod),
        .in_side   (prep_side),
        .out_valid (sq_v),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    ldf_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_v),
        .in_root   (sq_root),
        .in_side   (sq_side),
        .out_valid (dv_v),
        .out_fac   (dv_fac)
    );

    // clamp the cosine to the range zero to one and add the ambient term
    always_comb
    begin
        if (!dv_fac.pos)
        begin
            f = 17'd0;
        end
        else if (dv_fac.ovf || (dv_fac.q > ldf_pkg::FACTOR_ONE))
        begin
            f = ldf_pkg::FACTOR_ONE;
        end
        else
        begin
            f = dv_fac.q;
        end
        lf = {1'b0, f} + ldf_pkg::AMBIENT_Q;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rounded[i] = {1'b0, sh2_prod_reg[i]} + ldf_pkg::ROUND_HALF;
            chan[i]    = (rounded[i][26:24] != 3'd0) ? 8'hFF : rounded[i][23:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sh1_v_reg <= 1'b0;
            sh2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            sh1_v_reg <= dv_v;
            sh2_v_reg <= sh1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sh1_lf_reg      <= lf;
            sh1_rgba_reg    <= dv_fac.rgba;
            sh2_prod_reg[0] <= {18'd0, sh1_rgba_reg[31:24]} * {8'd0, sh1_lf_reg};
            sh2_prod_reg[1] <= {18'd0, sh1_rgba_reg[23:16]} * {8'd0, sh1_lf_reg};
            sh2_prod_reg[2] <= {18'd0, sh1_rgba_reg[15:8]} * {8'd0, sh1_lf_reg};
            sh2_a_reg       <= sh1_rgba_reg[7:0];
        end
    end

    // output buffer
    assign push = en && sh2_v_reg;
    assign pop  = pix.valid && pix.ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_mem[wr_ptr_reg] <= {chan[0], chan[1], chan[2], sh2_a_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assign pix.valid = (count_reg != 2'd0);
    assign pix.out_r = buf_mem[rd_ptr_reg][31:24];
    assign pix.out_g = buf_mem[rd_ptr_reg][23:16];
    assign pix.out_b = buf_mem[rd_ptr_reg][15:8];
    assign pix.out_a = buf_mem[rd_ptr_reg][7:0];

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("output buffer count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != 2'd2))
        else $error("push into a full output buffer");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !frag.ready |-> (sh2_v_reg && (count_reg == 2'd2)))
        else $error("pipeline stalled without a full buffer");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("buffer count lost a push");
`endif

endmodule
`default_nettype wire

// ===== sv/ldf_prep.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldf_prep
// light vector, range scaling, dot and length products (five stages)
// ----------------------------------------------------------------------------
module ldf_prep
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                en,
    input  wire                in_valid,
    input  wire  [31:0]        light_x,
    input  wire  [31:0]        light_y,
    input  wire  [31:0]        light_z,
    input  wire  [31:0]        pos_x,
    input  wire  [31:0]        pos_y,
    input  wire  [31:0]        pos_z,
    input  wire  [31:0]        norm_x,
    input  wire  [31:0]        norm_y,
    input  wire  [31:0]        norm_z,
    input  wire  [31:0]        rgba,
    output logic               out_valid,
    output logic [63:0]        out_prod,
    output ldf_pkg::ldf_side_t out_side
);

    function automatic logic [4:0] shift_of(input logic [31:0] m);
        logic [4:0] s;
        s = 5'd0;
        for (int i = 15; i < 32; i++)
        begin
            if (m[i])
            begin
                s = 5'(i - 14);
            end
        end
        return s;
    endfunction

    logic [31:0] lt [3];
    logic [31:0] ps [3];
    logic [31:0] nm [3];

    logic signed [32:0] dfull [3];
    logic signed [32:0] dabs  [3];
    logic signed [32:0] nfull [3];
    logic signed [32:0] nabs  [3];

    logic [31:0] s1_dmag_reg [3];
    logic [31:0] s1_nmag_reg [3];
    logic [2:0]  s1_dneg_reg;
    logic [2:0]  s1_nneg_reg;
    logic [31:0] s1_rgba_reg;
    logic        s1_v_reg;

    logic [4:0]         d_sh;
    logic [4:0]         n_sh;
    logic [31:0]        d_shifted [3];
    logic [31:0]        n_shifted [3];
    logic signed [15:0] ds_next   [3];
    logic signed [15:0] ns_next   [3];

    logic signed [15:0] s2_ds_reg [3];
    logic signed [15:0] s2_ns_reg [3];
    logic [31:0]        s2_rgba_reg;
    logic               s2_v_reg;

    logic signed [31:0] dn_next [3];
    logic signed [31:0] dd_next [3];
    logic signed [31:0] nn_next [3];

    logic signed [31:0] s3_dn_reg [3];
    logic [29:0]        s3_dd_reg [3];
    logic [29:0]        s3_nn_reg [3];
    logic [31:0]        s3_rgba_reg;
    logic               s3_v_reg;

    logic signed [32:0] s4_dot_reg;
    logic [31:0]        s4_dd_reg;
    logic [31:0]        s4_nn_reg;
    logic [31:0]        s4_rgba_reg;
    logic               s4_v_reg;

    logic [63:0]        s5_prod_reg;
    ldf_pkg::ldf_side_t s5_side_reg;
    logic               s5_v_reg;

    assign lt[0] = light_x;
    assign lt[1] = light_y;
    assign lt[2] = light_z;
    assign ps[0] = pos_x;
    assign ps[1] = pos_y;
    assign ps[2] = pos_z;
    assign nm[0] = norm_x;
    assign nm[1] = norm_y;
    assign nm[2] = norm_z;

    // stage 1: difference and magnitudes
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dfull[i] = $signed({lt[i][31], lt[i]}) - $signed({ps[i][31], ps[i]});
            dabs[i]  = dfull[i][32] ? (33'sd0 - dfull[i]) : dfull[i];
            nfull[i] = $signed({nm[i][31], nm[i]});
            nabs[i]  = nfull[i][32] ? (33'sd0 - nfull[i]) : nfull[i];
        end
    end

    // stage 2: bring every magnitude below 2^15, truncating toward zero
    always_comb
    begin
        d_sh = shift_of(s1_dmag_reg[0] | s1_dmag_reg[1] | s1_dmag_reg[2]);
        n_sh = shift_of(s1_nmag_reg[0] | s1_nmag_reg[1] | s1_nmag_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            d_shifted[i] = s1_dmag_reg[i] >> d_sh;
            n_shifted[i] = s1_nmag_reg[i] >> n_sh;
            ds_next[i] = s1_dneg_reg[i] ? (16'sd0 - $signed({1'b0, d_shifted[i][14:0]}))
                                        : $signed({1'b0, d_shifted[i][14:0]});
            ns_next[i] = s1_nneg_reg[i] ? (16'sd0 - $signed({1'b0, n_shifted[i][14:0]}))
                                        : $signed({1'b0, n_shifted[i][14:0]});
        end
    end

    // stage 3: products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dn_next[i] = s2_ds_reg[i] * s2_ns_reg[i];
            dd_next[i] = s2_ds_reg[i] * s2_ds_reg[i];
            nn_next[i] = s2_ns_reg[i] * s2_ns_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_dmag_reg[i] <= dabs[i][31:0];
                s1_nmag_reg[i] <= nabs[i][31:0];
                s1_dneg_reg[i] <= dfull[i][32];
                s1_nneg_reg[i] <= nfull[i][32];
                s2_ds_reg[i]   <= ds_next[i];
                s2_ns_reg[i]   <= ns_next[i];
                s3_dn_reg[i]   <= dn_next[i];
                s3_dd_reg[i]   <= dd_next[i][29:0];
                s3_nn_reg[i]   <= nn_next[i][29:0];
            end
            s1_rgba_reg <= rgba;
            s2_rgba_reg <= s1_rgba_reg;
            s3_rgba_reg <= s2_rgba_reg;

            s4_dot_reg  <= $signed({s3_dn_reg[0][31], s3_dn_reg[0]})
                         + $signed({s3_dn_reg[1][31], s3_dn_reg[1]})
                         + $signed({s3_dn_reg[2][31], s3_dn_reg[2]});
            s4_dd_reg   <= {2'b00, s3_dd_reg[0]} + {2'b00, s3_dd_reg[1]}
                         + {2'b00, s3_dd_reg[2]};
            s4_nn_reg   <= {2'b00, s3_nn_reg[0]} + {2'b00, s3_nn_reg[1]}
                         + {2'b00, s3_nn_reg[2]};
            s4_rgba_reg <= s3_rgba_reg;

            s5_prod_reg      <= {32'd0, s4_dd_reg} * {32'd0, s4_nn_reg};
            s5_side_reg.rgba <= s4_rgba_reg;
            s5_side_reg.dot  <= s4_dot_reg;
            s5_side_reg.nz   <= (s4_dd_reg != 32'd0) && (s4_nn_reg != 32'd0);
        end
    end

    assign out_valid = s5_v_reg;
    assign out_prod  = s5_prod_reg;
    assign out_side  = s5_side_reg;

endmodule
`default_nettype wire

// ===== sv/ldf_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldf_isqrt
// floor square root of a 64-bit value, one root bit per stage
// ----------------------------------------------------------------------------
module ldf_isqrt
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                en,
    input  wire                in_valid,
    input  wire  [63:0]        in_x,
    input  ldf_pkg::ldf_side_t in_side,
    output logic               out_valid,
    output logic [31:0]        out_root,
    output ldf_pkg::ldf_side_t out_side
);

    localparam int NS = 32;

    logic               v_reg    [NS];
    logic [63:0]        rem_reg  [NS];
    logic [31:0]        root_reg [NS];
    ldf_pkg::ldf_side_t side_reg [NS];

    for (genvar g = 0; g < NS; g++)
    begin : g_stage
        localparam int B = NS - 1 - g;

        logic               v_in;
        logic [63:0]        rem_in;
        logic [31:0]        root_in;
        ldf_pkg::ldf_side_t side_in;
        logic [65:0]        trial;
        logic               ge;

        if (g == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = in_x;
            assign root_in = 32'd0;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign v_in    = v_reg[g-1];
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
            assign side_in = side_reg[g-1];
        end

        // trial = (root << (b+1)) + 4^b
        assign trial = ({34'd0, root_in} << (B + 1)) + (66'd1 << (2 * B));
        assign ge    = ({2'b00, rem_in} >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[g] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]  <= ge ? (rem_in - trial[63:0]) : rem_in;
                root_reg[g] <= ge ? (root_in | (32'd1 << B)) : root_in;
                side_reg[g] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_root  = root_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule
`default_nettype wire

// ===== sv/ldf_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldf_div
// cosine factor dot * 2^16 / root, restoring division, one bit per stage
// ----------------------------------------------------------------------------
module ldf_div
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                en,
    input  wire                in_valid,
    input  wire  [31:0]        in_root,
    input  ldf_pkg::ldf_side_t in_side,
    output logic               out_valid,
    output ldf_pkg::ldf_fac_t  out_fac
);

    localparam int NQ = 17;

    typedef struct packed {
        logic [31:0] root;
        logic        pos;
        logic        ovf;
        logic [31:0] rgba;
    } div_ctx_t;

    logic     pos_next;
    logic     ovf_next;

    logic     p_v_reg;
    logic [47:0] p_rem_reg;
    div_ctx_t p_ctx_reg;

    logic        v_reg   [NQ];
    logic [47:0] rem_reg [NQ];
    logic [16:0] q_reg   [NQ];
    div_ctx_t    ctx_reg [NQ];

    assign pos_next = !in_side.dot[32] && (in_side.dot != 33'sd0) && in_side.nz
                      && (in_root != 32'd0);
    // quotient would reach 2^17 or more: clamps anyway
    assign ovf_next = ({1'b0, in_side.dot[31:0]} >= {in_root, 1'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_v_reg <= 1'b0;
        end
        else if (en)
        begin
            p_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_rem_reg      <= {in_side.dot[31:0], 16'd0};
            p_ctx_reg.root <= in_root;
            p_ctx_reg.pos  <= pos_next;
            p_ctx_reg.ovf  <= ovf_next;
            p_ctx_reg.rgba <= in_side.rgba;
        end
    end

    for (genvar g = 0; g < NQ; g++)
    begin : g_stage
        localparam int K = NQ - 1 - g;

        logic        v_in;
        logic [47:0] rem_in;
        logic [16:0] q_in;
        div_ctx_t    ctx_in;
        logic [48:0] dsh;
        logic [48:0] diff;
        logic        ge;

        if (g == 0)
        begin : g_first
            assign v_in   = p_v_reg;
            assign rem_in = p_rem_reg;
            assign q_in   = 17'd0;
            assign ctx_in = p_ctx_reg;
        end
        else
        begin : g_next
            assign v_in   = v_reg[g-1];
            assign rem_in = rem_reg[g-1];
            assign q_in   = q_reg[g-1];
            assign ctx_in = ctx_reg[g-1];
        end

        assign dsh  = {17'd0, ctx_in.root} << K;
        assign ge   = ({1'b0, rem_in} >= dsh);
        assign diff = {1'b0, rem_in} - dsh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[g] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g] <= ge ? diff[47:0] : rem_in;
                q_reg[g]   <= ge ? (q_in | (17'd1 << K)) : q_in;
                ctx_reg[g] <= ctx_in;
            end
        end
    end

    assign out_valid    = v_reg[NQ-1];
    assign out_fac.q    = q_reg[NQ-1];
    assign out_fac.pos  = ctx_reg[NQ-1].pos;
    assign out_fac.ovf  = ctx_reg[NQ-1].ovf;
    assign out_fac.rgba = ctx_reg[NQ-1].rgba;

endmodule
`default_nettype wire
